>>> src/iou_blob_tracker_defines.svh
// Assertion macros shared by the blob tracker RTL.
`ifndef IOU_BLOB_TRACKER_DEFINES_SVH
`define IOU_BLOB_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IOU_BT_ASSERT_IMP(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IOU_BT_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/iou_bt_pkg.sv
// Types, codes and fixed widths shared by the blob tracker modules.
package iou_bt_pkg;

    localparam int POS_BITS       = 12;
    localparam int SIZE_BITS      = 13;
    localparam int END_BITS       = 14;
    localparam int SEEN_BITS      = 16;
    localparam int BLOB_ID_BITS   = 16;
    localparam int TENTHS_BITS    = 4;
    localparam int LIMIT_BITS     = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int KIND_BITS      = 3;
    localparam int PROD_BITS      = 28;
    localparam int CMP_BITS       = 32;

    localparam logic [SEEN_BITS-1:0] SEEN_MAX = '1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERLAP_TENTHS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRUNE_LIMIT    = 1'b1;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_MATCHED    = 3'd0,
        KIND_CREATED    = 3'd1,
        KIND_DROPPED    = 3'd2,
        KIND_ACTIVE     = 3'd3,
        KIND_FRAME_DONE = 3'd4
    } result_kind_t;

    typedef enum logic {
        REQ_RECT      = 1'b0,
        REQ_FRAME_END = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FRAME,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic [POS_BITS-1:0]  x;
        logic [POS_BITS-1:0]  y;
        logic [SIZE_BITS-1:0] w;
        logic [SIZE_BITS-1:0] h;
    } box_t;

    typedef struct packed {
        req_type_t            req_type;
        logic [POS_BITS-1:0]  rect_x;
        logic [POS_BITS-1:0]  rect_y;
        logic [SIZE_BITS-1:0] rect_w;
        logic [SIZE_BITS-1:0] rect_h;
    } in_item_t;

    typedef struct packed {
        result_kind_t            result_kind;
        logic [BLOB_ID_BITS-1:0] blob_id;
        logic [POS_BITS-1:0]     box_x;
        logic [POS_BITS-1:0]     box_y;
        logic [SIZE_BITS-1:0]    box_w;
        logic [SIZE_BITS-1:0]    box_h;
        logic [SIZE_BITS-1:0]    center_x;
        logic [SIZE_BITS-1:0]    center_y;
        logic [SEEN_BITS-1:0]    seen_count;
        logic                    last;
    } out_item_t;

endpackage

>>> src/iou_bt_table.sv
// Entry table memory: one write port and one registered read port.
module iou_bt_table #(
    parameter int DEPTH     = 32,
    parameter int IDX_BITS  = 5,
    parameter int WORD_BITS = 82
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_BITS-1:0]  wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [IDX_BITS-1:0]  rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/iou_bt_overlap.sv
// Pipelined overlap test: intersection over bounding area against a threshold.
module iou_bt_overlap #(
    parameter int TAG_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 flush,
    input  logic                                 in_valid,
    input  logic [TAG_BITS-1:0]                  in_tag,
    input  iou_bt_pkg::box_t                     entry_box,
    input  iou_bt_pkg::box_t                     new_box,
    input  logic [iou_bt_pkg::TENTHS_BITS-1:0]   tenths,
    output logic                                 out_valid,
    output logic                                 out_match,
    output logic [TAG_BITS-1:0]                  out_tag
);

    import iou_bt_pkg::*;

    typedef struct packed {
        logic [POS_BITS-1:0]  ix1;
        logic [END_BITS-1:0]  ix2;
        logic [POS_BITS-1:0]  iy1;
        logic [END_BITS-1:0]  iy2;
        logic [POS_BITS-1:0]  ux1;
        logic [END_BITS-1:0]  ux2;
        logic [POS_BITS-1:0]  uy1;
        logic [END_BITS-1:0]  uy2;
        logic                 a_empty;
        logic                 b_empty;
        logic [SIZE_BITS-1:0] aw;
        logic [SIZE_BITS-1:0] ah;
        logic [SIZE_BITS-1:0] bw;
        logic [SIZE_BITS-1:0] bh;
        logic [TAG_BITS-1:0]  tag;
    } stage_a_t;

    typedef struct packed {
        logic [END_BITS-1:0] iw;
        logic [END_BITS-1:0] ih;
        logic [END_BITS-1:0] pw;
        logic [END_BITS-1:0] ph;
        logic [TAG_BITS-1:0] tag;
    } stage_b_t;

    typedef struct packed {
        logic [PROD_BITS-1:0] inter;
        logic [PROD_BITS-1:0] uni;
        logic [TAG_BITS-1:0]  tag;
    } stage_c_t;

    typedef struct packed {
        logic [CMP_BITS-1:0] inter10;
        logic [CMP_BITS-1:0] thr;
        logic                uni_zero;
        logic [TAG_BITS-1:0] tag;
    } stage_d_t;

    stage_a_t a_next, a_reg;
    stage_b_t b_next, b_reg;
    stage_c_t c_next, c_reg;
    stage_d_t d_next, d_reg;
    logic [3:0] valid_next, valid_reg;

    logic [END_BITS-1:0] a_end_x, a_end_y, b_end_x, b_end_y;
    logic [END_BITS-1:0] uw, uh;

    // Stage A: box right and bottom edges, corners of the overlap and the bounding box.
    always_comb
    begin
        a_end_x = END_BITS'(entry_box.x) + END_BITS'(entry_box.w);
        a_end_y = END_BITS'(entry_box.y) + END_BITS'(entry_box.h);
        b_end_x = END_BITS'(new_box.x) + END_BITS'(new_box.w);
        b_end_y = END_BITS'(new_box.y) + END_BITS'(new_box.h);
        a_next.ix1 = (entry_box.x > new_box.x) ? entry_box.x : new_box.x;
        a_next.iy1 = (entry_box.y > new_box.y) ? entry_box.y : new_box.y;
        a_next.ux1 = (entry_box.x < new_box.x) ? entry_box.x : new_box.x;
        a_next.uy1 = (entry_box.y < new_box.y) ? entry_box.y : new_box.y;
        a_next.ix2 = (a_end_x < b_end_x) ? a_end_x : b_end_x;
        a_next.iy2 = (a_end_y < b_end_y) ? a_end_y : b_end_y;
        a_next.ux2 = (a_end_x > b_end_x) ? a_end_x : b_end_x;
        a_next.uy2 = (a_end_y > b_end_y) ? a_end_y : b_end_y;
        a_next.a_empty = (entry_box.w == '0) || (entry_box.h == '0);
        a_next.b_empty = (new_box.w == '0) || (new_box.h == '0);
        a_next.aw = entry_box.w;
        a_next.ah = entry_box.h;
        a_next.bw = new_box.w;
        a_next.bh = new_box.h;
        a_next.tag = in_tag;
    end

    // Stage B: side lengths. An empty box leaves the other box as the bounding area.
    always_comb
    begin
        uw = a_reg.ux2 - END_BITS'(a_reg.ux1);
        uh = a_reg.uy2 - END_BITS'(a_reg.uy1);
        b_next.iw = (a_reg.ix2 > END_BITS'(a_reg.ix1)) ? (a_reg.ix2 - END_BITS'(a_reg.ix1)) : '0;
        b_next.ih = (a_reg.iy2 > END_BITS'(a_reg.iy1)) ? (a_reg.iy2 - END_BITS'(a_reg.iy1)) : '0;
        priority if (a_reg.a_empty)
        begin
            b_next.pw = END_BITS'(a_reg.bw);
            b_next.ph = END_BITS'(a_reg.bh);
        end
        else if (a_reg.b_empty)
        begin
            b_next.pw = END_BITS'(a_reg.aw);
            b_next.ph = END_BITS'(a_reg.ah);
        end
        else
        begin
            b_next.pw = uw;
            b_next.ph = uh;
        end
        b_next.tag = a_reg.tag;
    end

    // Stage C: the two areas.
    always_comb
    begin
        c_next.inter = PROD_BITS'(b_reg.iw) * PROD_BITS'(b_reg.ih);
        c_next.uni   = PROD_BITS'(b_reg.pw) * PROD_BITS'(b_reg.ph);
        c_next.tag   = b_reg.tag;
    end

    // Stage D: cross-multiplied sides of the ratio compare.
    always_comb
    begin
        d_next.inter10  = (CMP_BITS'(c_reg.inter) << 3) + (CMP_BITS'(c_reg.inter) << 1);
        d_next.thr      = CMP_BITS'(tenths) * CMP_BITS'(c_reg.uni);
        d_next.uni_zero = (c_reg.uni == '0);
        d_next.tag      = c_reg.tag;
    end

    assign valid_next = flush ? 4'b0000 : {valid_reg[2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign out_valid = valid_reg[3];
    assign out_match = !d_reg.uni_zero && (d_reg.inter10 > d_reg.thr);
    assign out_tag   = d_reg.tag;

endmodule

>>> src/iou_blob_tracker.sv
// Blob tracker top level: sequencer, entry table and the shared overlap pipeline.
// Rectangle: N stored entries are read one per cycle into a four-stage overlap pipeline;
// a hit ends the scan with a match; a miss after the last entry (at once if empty) creates or drops.
// End of frame: one table pass of N reads, then the frame done transfer (also if empty).
// The table read port and the single overlap pipeline serve every entry; one item at a time.
// Reset clears the entry count, active marks and sequencer, sets the id counter to one.
`include "iou_blob_tracker_defines.svh"

module iou_blob_tracker #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDENT_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  iou_bt_pkg::in_item_t                   req,
    input  logic                                   cfg_write,
    input  logic [iou_bt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [iou_bt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                   result_valid,
    output iou_bt_pkg::out_item_t                  result
);

    import iou_bt_pkg::*;

    localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

    // One stored table entry.
    typedef struct packed {
        logic [IDENT_BITS-1:0] ident;
        logic [SEEN_BITS-1:0]  seen;
        box_t                  box;
    } entry_t;

    // What travels with an entry through the overlap pipeline.
    typedef struct packed {
        logic [IDX_BITS-1:0]   idx;
        logic [IDENT_BITS-1:0] ident;
        logic [SEEN_BITS-1:0]  seen;
    } tag_t;

    localparam int WORD_BITS = $bits(entry_t);
    localparam int TAG_BITS  = $bits(tag_t);

    // Sequencer state and control registers.
    state_t                   state_reg, state_next;
    logic [CNT_BITS-1:0]      issue_reg, issue_next;
    logic [CNT_BITS-1:0]      kept_reg, kept_next;
    logic [CNT_BITS-1:0]      total_reg, total_next;
    logic [IDENT_BITS-1:0]    next_ident_reg, next_ident_next;
    logic [TABLE_DEPTH-1:0]   active_reg, active_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic                     result_valid_reg, result_valid_next;
    logic [TENTHS_BITS-1:0]   overlap_tenths_reg;
    logic [LIMIT_BITS-1:0]    prune_limit_reg;

    // Payload registers.
    box_t                     rect_reg, rect_next;
    logic [IDX_BITS-1:0]      rd_idx_reg, rd_idx_next;
    out_item_t                result_reg, result_next;

    // Table port signals.
    logic                     mem_wr_en;
    logic [IDX_BITS-1:0]      mem_wr_addr;
    entry_t                   mem_wr_data;
    logic                     mem_rd_en;
    logic [WORD_BITS-1:0]     mem_rd_word;
    entry_t                   rd_entry;

    // Overlap pipeline signals.
    tag_t                     ov_in_tag;
    logic                     ov_valid;
    logic                     ov_match;
    logic [TAG_BITS-1:0]      ov_tag_bits;
    tag_t                     ov_tag;
    logic                     ov_flush;

    // Decision helpers.
    logic                     scan_hit;
    logic                     scan_miss;
    logic                     entry_act;
    logic                     entry_keep;
    logic [SEEN_BITS-1:0]     seen_inc;

    // Builds one result transfer; the center is the left or top edge plus half the size.
    function automatic out_item_t make_result(
        result_kind_t          kind,
        logic [IDENT_BITS-1:0] ident,
        box_t                  b,
        logic [SEEN_BITS-1:0]  seen,
        logic                  is_last
    );
        out_item_t   r;
        logic [31:0] id_wide;
        id_wide      = 32'(ident);
        r.result_kind = kind;
        r.blob_id    = id_wide[BLOB_ID_BITS-1:0];
        r.box_x      = b.x;
        r.box_y      = b.y;
        r.box_w      = b.w;
        r.box_h      = b.h;
        r.center_x   = SIZE_BITS'(b.x) + SIZE_BITS'(b.w >> 1);
        r.center_y   = SIZE_BITS'(b.y) + SIZE_BITS'(b.h >> 1);
        r.seen_count = seen;
        r.last       = is_last;
        return r;
    endfunction

    // The entry table. A read issued in one cycle returns its entry in the next.
    iou_bt_table #(
        .DEPTH     (TABLE_DEPTH),
        .IDX_BITS  (IDX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (issue_reg[IDX_BITS-1:0]),
        .rd_data (mem_rd_word)
    );

    assign rd_entry = entry_t'(mem_rd_word);

    // The overlap pipeline takes every entry that the table returns during a scan.
    assign ov_in_tag.idx   = rd_idx_reg;
    assign ov_in_tag.ident = rd_entry.ident;
    assign ov_in_tag.seen  = rd_entry.seen;

    iou_bt_overlap #(
        .TAG_BITS (TAG_BITS)
    ) u_overlap (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (ov_flush),
        .in_valid  (rd_valid_reg && (state_reg == ST_SCAN)),
        .in_tag    (ov_in_tag),
        .entry_box (rd_entry.box),
        .new_box   (rect_reg),
        .tenths    (overlap_tenths_reg),
        .out_valid (ov_valid),
        .out_match (ov_match),
        .out_tag   (ov_tag_bits)
    );

    assign ov_tag = tag_t'(ov_tag_bits);

    // Results leave the pipeline in table order, so the first hit is the one to take.
    // The scan misses once the last stored entry has come back without a hit, or at once if the table is empty.
    assign scan_hit  = (state_reg == ST_SCAN) && ov_valid && ov_match;
    assign scan_miss = (state_reg == ST_SCAN)
                       && ((total_reg == '0)
                           || (ov_valid && !ov_match
                               && (CNT_BITS'(ov_tag.idx) + CNT_BITS'(1) == total_reg)));
    assign seen_inc  = (ov_tag.seen == SEEN_MAX) ? ov_tag.seen : ov_tag.seen + SEEN_BITS'(1);

    // During the frame pass an entry stays unless it is inactive and stale.
    assign entry_act  = active_reg[rd_idx_reg];
    assign entry_keep = entry_act || (rd_entry.seen <= prune_limit_reg);

    always_comb
    begin
        state_next        = state_reg;
        issue_next        = issue_reg;
        kept_next         = kept_reg;
        total_next        = total_reg;
        next_ident_next   = next_ident_reg;
        active_next       = active_reg;
        rect_next         = rect_reg;
        rd_valid_next     = 1'b0;
        rd_idx_next       = rd_idx_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = kept_reg[IDX_BITS-1:0];
        mem_wr_data       = rd_entry;
        mem_rd_en         = 1'b0;
        ov_flush          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rect_next.x = req.rect_x;
                    rect_next.y = req.rect_y;
                    rect_next.w = req.rect_w;
                    rect_next.h = req.rect_h;
                    issue_next  = '0;
                    kept_next   = '0;
                    state_next  = (req.req_type == REQ_RECT) ? ST_SCAN : ST_FRAME;
                end
            end

            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    // Matched entry takes the new box; entries still in flight are dropped.
                    ov_flush              = 1'b1;
                    mem_wr_en             = 1'b1;
                    mem_wr_addr           = ov_tag.idx;
                    mem_wr_data.ident     = ov_tag.ident;
                    mem_wr_data.seen      = seen_inc;
                    mem_wr_data.box       = rect_reg;
                    active_next[ov_tag.idx] = 1'b1;
                    result_next           = make_result(KIND_MATCHED, ov_tag.ident, rect_reg,
                                                        seen_inc, 1'b1);
                    result_valid_next     = 1'b1;
                    state_next            = ST_IDLE;
                end
                else if (scan_miss)
                begin
                    if (total_reg == CNT_BITS'(TABLE_DEPTH))
                    begin
                        result_next = make_result(KIND_DROPPED, '0, rect_reg, '0, 1'b1);
                    end
                    else
                    begin
                        mem_wr_en         = 1'b1;
                        mem_wr_addr       = total_reg[IDX_BITS-1:0];
                        mem_wr_data.ident = next_ident_reg;
                        mem_wr_data.seen  = SEEN_BITS'(1);
                        mem_wr_data.box   = rect_reg;
                        active_next[total_reg[IDX_BITS-1:0]] = 1'b1;
                        total_next        = total_reg + CNT_BITS'(1);
                        next_ident_next   = next_ident_reg + IDENT_BITS'(1);
                        result_next       = make_result(KIND_CREATED, next_ident_reg, rect_reg,
                                                        SEEN_BITS'(1), 1'b1);
                    end
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else if (issue_reg < total_reg)
                begin
                    mem_rd_en     = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = issue_reg[IDX_BITS-1:0];
                    issue_next    = issue_reg + CNT_BITS'(1);
                end
            end

            ST_FRAME:
            begin
                // Kept entries slide down to the next free slot; the write never passes
                // the read position, so no entry is overwritten before it is read.
                if (rd_valid_reg && entry_keep)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = kept_reg[IDX_BITS-1:0];
                    mem_wr_data = rd_entry;
                    kept_next   = kept_reg + CNT_BITS'(1);
                    if (entry_act)
                    begin
                        result_next       = make_result(KIND_ACTIVE, rd_entry.ident, rd_entry.box,
                                                        rd_entry.seen, 1'b0);
                        result_valid_next = 1'b1;
                    end
                end
                if (issue_reg < total_reg)
                begin
                    mem_rd_en     = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = issue_reg[IDX_BITS-1:0];
                    issue_next    = issue_reg + CNT_BITS'(1);
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_CLOSE;
                end
            end

            ST_CLOSE:
            begin
                total_next             = kept_reg;
                active_next            = '0;
                result_next            = '0;
                result_next.result_kind = KIND_FRAME_DONE;
                result_next.last       = 1'b1;
                result_valid_next      = 1'b1;
                state_next             = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg        <= '0;
            kept_reg         <= '0;
            total_reg        <= '0;
            next_ident_reg   <= IDENT_BITS'(1);
            active_reg       <= '0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            issue_reg        <= issue_next;
            kept_reg         <= kept_next;
            total_reg        <= total_next;
            next_ident_reg   <= next_ident_next;
            active_reg       <= active_next;
            rd_valid_reg     <= rd_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rect_reg   <= rect_next;
        rd_idx_reg <= rd_idx_next;
        result_reg <= result_next;
    end

    // Configuration registers take a write in the cycle it is presented.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_tenths_reg <= TENTHS_BITS'(3);
            prune_limit_reg    <= LIMIT_BITS'(30);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OVERLAP_TENTHS: overlap_tenths_reg <= cfg_data[TENTHS_BITS-1:0];
                CFG_PRUNE_LIMIT:    prune_limit_reg    <= cfg_data[LIMIT_BITS-1:0];
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The entry count never grows past the table.
    `IOU_BT_ASSERT_IMP(a_total_bounded, clk, rst_n, 1'b1,
        total_reg <= CNT_BITS'(TABLE_DEPTH), "entry count exceeds table depth")
    // A frame-done transfer leaves no entry marked active.
    `IOU_BT_ASSERT_IMP(a_frame_clears_active, clk, rst_n,
        result_valid_reg && (result_reg.result_kind == KIND_FRAME_DONE),
        active_reg == '0, "active marks survive frame end")
    // An accepted item makes the block busy in the next cycle.
    `IOU_BT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy,
        "accepted item did not start work")
    // The final transfer of an item finds the sequencer back at idle.
    `IOU_BT_ASSERT_IMP(a_last_idle, clk, rst_n, result_valid_reg && result_reg.last, !busy,
        "final transfer while still busy")

endmodule

>>> tb/iou_blob_tracker_tb.sv
// Self-checking testbench for the blob tracker: table mirror, stimulus and result checks.
import iou_bt_pkg::*;

class track_table_mirror #(int DEPTH = 32);
    box_t        boxes[DEPTH];
    logic [15:0] idents[DEPTH];
    logic [15:0] seen[DEPTH];
    bit          active[DEPTH];
    int          total;
    logic [15:0] next_id;
    logic [3:0]  tenths;
    logic [15:0] prune_above;
    out_item_t   upcoming_reports[$];
    int          failures;
    int          reports_checked;
    int          kind_tally[5];

    function new();
        total = 0;
        next_id = 16'd1;
        tenths = 4'd3;
        prune_above = 16'd30;
        failures = 0;
        reports_checked = 0;
        foreach (active[i]) active[i] = 1'b0;
        foreach (kind_tally[k]) kind_tally[k] = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] index,
                               logic [CFG_DATA_BITS-1:0] data);
        if (index == CFG_OVERLAP_TENTHS)
            tenths = data[TENTHS_BITS-1:0];
        else
            prune_above = data;
    endfunction

    function longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    // Intersection over bounding-rectangle area, compared without division.
    function bit overlaps_enough(box_t a, box_t b);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, inter, span;
        ax0 = a.x;
        ay0 = a.y;
        ax1 = ax0 + a.w;
        ay1 = ay0 + a.h;
        bx0 = b.x;
        by0 = b.y;
        bx1 = bx0 + b.w;
        by1 = by0 + b.h;
        inter = 0;
        if (lmin(ax1, bx1) > lmax(ax0, bx0) && lmin(ay1, by1) > lmax(ay0, by0))
            inter = (lmin(ax1, bx1) - lmax(ax0, bx0)) * (lmin(ay1, by1) - lmax(ay0, by0));
        if (a.w == 0 || a.h == 0)
            span = longint'(b.w) * longint'(b.h);
        else if (b.w == 0 || b.h == 0)
            span = longint'(a.w) * longint'(a.h);
        else
            span = (lmax(ax1, bx1) - lmin(ax0, bx0)) * (lmax(ay1, by1) - lmin(ay0, by0));
        if (span == 0)
            return 1'b0;
        return inter * 10 > longint'(tenths) * span;
    endfunction

    function out_item_t make_report(result_kind_t kind, logic [15:0] id, box_t b,
                                    logic [15:0] cnt, logic fin);
        out_item_t r;
        int        cx, cy;
        cx = int'(b.x) + int'(b.w) / 2;
        cy = int'(b.y) + int'(b.h) / 2;
        r.result_kind = kind;
        r.blob_id = id;
        r.box_x = b.x;
        r.box_y = b.y;
        r.box_w = b.w;
        r.box_h = b.h;
        r.center_x = SIZE_BITS'(cx);
        r.center_y = SIZE_BITS'(cy);
        r.seen_count = cnt;
        r.last = fin;
        return r;
    endfunction

    // Appends one report to the end of the pending list.
    function void queue_report(out_item_t r);
        upcoming_reports = {upcoming_reports, r};
    endfunction

    function void accept_request(in_item_t item);
        box_t nb, blank;
        int   i, kept;
        bit   hit;
        blank = '0;
        if (item.req_type == REQ_RECT) begin
            nb.x = item.rect_x;
            nb.y = item.rect_y;
            nb.w = item.rect_w;
            nb.h = item.rect_h;
            hit = 1'b0;
            for (i = 0; i < total && !hit; i++) begin
                if (overlaps_enough(boxes[i], nb)) begin
                    hit = 1'b1;
                    boxes[i] = nb;
                    if (seen[i] != SEEN_MAX)
                        seen[i]++;
                    active[i] = 1'b1;
                    queue_report(make_report(KIND_MATCHED, idents[i], nb, seen[i], 1'b1));
                end
            end
            if (!hit && total >= DEPTH) begin
                queue_report(make_report(KIND_DROPPED, '0, nb, '0, 1'b1));
            end else if (!hit) begin
                boxes[total] = nb;
                idents[total] = next_id;
                next_id++;
                seen[total] = 16'd1;
                active[total] = 1'b1;
                queue_report(make_report(KIND_CREATED, idents[total], nb, 16'd1, 1'b1));
                total++;
            end
        end else begin
            // Drop stale entries and close the gaps, keeping table order.
            kept = 0;
            for (i = 0; i < total; i++) begin
                if (active[i] || seen[i] <= prune_above) begin
                    boxes[kept] = boxes[i];
                    idents[kept] = idents[i];
                    seen[kept] = seen[i];
                    active[kept] = active[i];
                    kept++;
                end
            end
            total = kept;
            for (i = 0; i < total; i++) begin
                if (active[i])
                    queue_report(
                        make_report(KIND_ACTIVE, idents[i], boxes[i], seen[i], 1'b0));
                active[i] = 1'b0;
            end
            queue_report(make_report(KIND_FRAME_DONE, '0, blank, '0, 1'b1));
        end
    endfunction

    function string describe(out_item_t r);
        return $sformatf("kind=%0d id=%0d box=(%0d,%0d,%0d,%0d) center=(%0d,%0d) seen=%0d last=%0b",
                         r.result_kind, r.blob_id, r.box_x, r.box_y, r.box_w, r.box_h,
                         r.center_x, r.center_y, r.seen_count, r.last);
    endfunction

    function void record_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void check_report(out_item_t got);
        out_item_t want;
        string     diffs;
        reports_checked++;
        if (upcoming_reports.size() == 0) begin
            record_failure({"result with nothing pending: ", describe(got)});
            return;
        end
        want = upcoming_reports.pop_front();
        kind_tally[int'(want.result_kind)]++;
        diffs = "";
        if (got.result_kind !== want.result_kind) diffs = {diffs, " result_kind"};
        if (got.blob_id !== want.blob_id) diffs = {diffs, " blob_id"};
        if (got.box_x !== want.box_x) diffs = {diffs, " box_x"};
        if (got.box_y !== want.box_y) diffs = {diffs, " box_y"};
        if (got.box_w !== want.box_w) diffs = {diffs, " box_w"};
        if (got.box_h !== want.box_h) diffs = {diffs, " box_h"};
        if (got.center_x !== want.center_x) diffs = {diffs, " center_x"};
        if (got.center_y !== want.center_y) diffs = {diffs, " center_y"};
        if (got.seen_count !== want.seen_count) diffs = {diffs, " seen_count"};
        if (got.last !== want.last) diffs = {diffs, " last"};
        if (diffs != "")
            record_failure($sformatf("mismatch in%s\n    expected %s\n    actual   %s",
                                     diffs, describe(want), describe(got)));
    endfunction
endclass

module iou_blob_tracker_tb;
    localparam int TRACK_DEPTH  = 32;
    // A correct run has no long stretch without a transfer (a drain, a sender gap
    // and a full table scan are the longest), so this limit is generous.
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = TRACK_DEPTH + 16;
    localparam int RANDOM_ITEMS = 400;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    in_item_t                  req;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      result_valid;
    out_item_t                 result;

    track_table_mirror #(TRACK_DEPTH) tracker;
    int requests_sent;
    int settings_used;
    int quiet_cycles;
    // When set, the sender offers items back to back with no gaps.
    bit no_gaps;

    iou_blob_tracker #(
        .TABLE_DEPTH(TRACK_DEPTH),
        .IDENT_BITS (16)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result_valid(result_valid),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every result strobe is a transfer; it is checked against the oldest
    // pending report. Values are sampled as they stood before the edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            tracker.check_report(result);
    end

    // Watchdog: ends the run if neither side makes a transfer for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && busy === 1'b0) || result_valid === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: %0d cycles without a transfer", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic in_item_t rect_item(int x, int y, int w, int h);
        in_item_t item;
        item.req_type = REQ_RECT;
        item.rect_x = POS_BITS'(x);
        item.rect_y = POS_BITS'(y);
        item.rect_w = SIZE_BITS'(w);
        item.rect_h = SIZE_BITS'(h);
        return item;
    endfunction

    // The geometry fields of an end-of-frame item are ignored, so they carry noise.
    function automatic in_item_t frame_end_item();
        in_item_t item;
        item.req_type = REQ_FRAME_END;
        item.rect_x = POS_BITS'($urandom);
        item.rect_y = POS_BITS'($urandom);
        item.rect_w = SIZE_BITS'($urandom);
        item.rect_h = SIZE_BITS'($urandom);
        return item;
    endfunction

    function automatic int wobble(int v);
        return v + int'($urandom_range(0, 12)) - 6;
    endfunction

    // Most rectangles follow a tracked box with a little motion, so that
    // matches are frequent; the rest are noise of any size, small boxes
    // and empty ones included. Sizes that wrap below zero are kept as is.
    function automatic in_item_t random_rect();
        box_t b;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 60 && tracker.total > 0) begin
            b = tracker.boxes[$urandom_range(0, tracker.total - 1)];
            return rect_item(wobble(b.x), wobble(b.y), wobble(b.w), wobble(b.h));
        end
        if (pick < 85)
            return rect_item($urandom, $urandom, $urandom, $urandom);
        return rect_item($urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 64), $urandom_range(0, 64));
    endfunction

    // Offers one item after a random gap and returns right after the edge
    // at which it was taken. With no gap, start simply stays high.
    task automatic send_item(in_item_t item);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req <= item;
        do @(posedge clk); while (busy !== 1'b0);
        tracker.accept_request(item);
        requests_sent++;
    endtask

    // Holds the sender until every pending report has come out and the block
    // is idle, then writes both registers on consecutive cycles.
    task automatic drain_and_configure(logic [TENTHS_BITS-1:0] tenths,
                                       logic [LIMIT_BITS-1:0] prune);
        @(negedge clk);
        start <= 1'b0;
        while (tracker.upcoming_reports.size() != 0) @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_OVERLAP_TENTHS;
        cfg_data <= CFG_DATA_BITS'(tenths);
        @(negedge clk);
        cfg_index <= CFG_PRUNE_LIMIT;
        cfg_data <= prune;
        @(negedge clk);
        cfg_write <= 1'b0;
        tracker.set_register(CFG_OVERLAP_TENTHS, CFG_DATA_BITS'(tenths));
        tracker.set_register(CFG_PRUNE_LIMIT, prune);
        settings_used++;
    endtask

    initial
    begin
        logic [TENTHS_BITS-1:0] tenths;
        logic [LIMIT_BITS-1:0]  prune;
        int                     frames;
        int                     rects;
        int                     i;
        int                     j;
        int                     target;

        tracker = new();
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_OVERLAP_TENTHS;
        cfg_data = '0;
        no_gaps = 1'b0;
        requests_sent = 0;
        settings_used = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Default threshold, and a prune limit of one so that
        // entries matched twice are removed once they go quiet.
        drain_and_configure(4'd3, 16'd1);
        send_item(frame_end_item());                      // empty table: frame done only
        send_item(rect_item(4095, 4095, 8191, 8191));     // largest fields, new entry
        send_item(rect_item(4095, 4095, 8191, 8191));     // same box matches it
        send_item(rect_item(0, 0, 0, 0));                 // empty box never intersects
        send_item(rect_item(0, 0, 0, 5));                 // empty against empty: zero union
        send_item(rect_item(0, 0, 100, 100));
        send_item(rect_item(10, 10, 100, 100));           // ratio about two thirds: match
        send_item(rect_item(60, 60, 100, 100));           // ratio about a ninth: new entry
        send_item(frame_end_item());                      // every entry reported
        send_item(frame_end_item());                      // twice-seen idle entries pruned

        // A threshold of ten can never be beaten, even by an identical box.
        drain_and_configure(4'd10, 16'd0);
        send_item(rect_item(60, 60, 100, 100));
        send_item(frame_end_item());

        // A threshold of zero takes any positive overlap; touching edges are not one.
        drain_and_configure(4'd0, 16'hFFFF);
        send_item(rect_item(159, 159, 10, 10));
        send_item(rect_item(160, 160, 10, 10));

        // The largest register value, above ten.
        drain_and_configure(4'd15, 16'hFFFF);
        send_item(rect_item(160, 160, 10, 10));
        send_item(frame_end_item());

        target = requests_sent + RANDOM_ITEMS;

        // Fill the table: clear it out, then offer more rectangles than it
        // holds with matching disabled, so the last ones are dropped and the
        // closing frame reports a full table.
        drain_and_configure(4'd15, 16'd0);
        send_item(frame_end_item());
        send_item(frame_end_item());
        for (i = 0; i < TRACK_DEPTH + 3; i++)
            send_item(random_rect());
        send_item(frame_end_item());
        send_item(frame_end_item());

        // Random phases: each picks a setting and an idling style, then runs
        // a few frames of tracked and noisy rectangles.
        while (requests_sent < target)
        begin
            case ($urandom_range(0, 6))
                0: tenths = 4'd0;
                1: tenths = 4'd10;
                2: tenths = 4'd15;
                default: tenths = TENTHS_BITS'($urandom_range(1, 9));
            endcase
            case ($urandom_range(0, 6))
                0: prune = 16'd0;
                1: prune = 16'hFFFF;
                2: prune = 16'd30;
                3: prune = LIMIT_BITS'($urandom);
                default: prune = LIMIT_BITS'($urandom_range(1, 4));
            endcase
            drain_and_configure(tenths, prune);
            no_gaps = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(2, 8);
            for (i = 0; i < frames; i++)
            begin
                rects = $urandom_range(0, 9);
                for (j = 0; j < rects; j++)
                    send_item(random_rect());
                send_item(frame_end_item());
            end
        end

        // Let the last reports come out, then watch for stray results.
        @(negedge clk);
        start <= 1'b0;
        while (tracker.upcoming_reports.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests under %0d register settings, %0d results checked:",
                 requests_sent, settings_used, tracker.reports_checked);
        $display("  %0d matched, %0d created, %0d dropped, %0d active reports, %0d frames closed",
                 tracker.kind_tally[KIND_MATCHED], tracker.kind_tally[KIND_CREATED],
                 tracker.kind_tally[KIND_DROPPED], tracker.kind_tally[KIND_ACTIVE],
                 tracker.kind_tally[KIND_FRAME_DONE]);
        if (tracker.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
